// ===== sv/okl_pkg.sv =====
// Package for the linear RGB to Oklab core: fixed matrix coefficients,
// widths and the divide-by-65535 helpers.
// No dependencies.
package okl_pkg;

    localparam int CUBE_W = 56;
    localparam int ROOT_W = 18;
    localparam int SQR_W  = 36;

    typedef logic [2:0][CUBE_W-1:0] okl_cube_t;
    typedef logic [2:0][ROOT_W-1:0] okl_root_t;
    typedef logic [2:0][SQR_W-1:0]  okl_sqr_t;
    typedef logic [2:0][16:0]       okl_q16_t;

    // Cone matrix, Q0.30, round to nearest
    localparam logic [63:0] C00 = (64'd4122214708 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C01 = (64'd5363325363 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C02 = (64'd514459929  * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C10 = (64'd2119034982 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C11 = (64'd6806995451 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C12 = (64'd1073969566 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C20 = (64'd883024619  * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C21 = (64'd2817188376 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C22 = (64'd6299787005 * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;

    localparam logic [29:0] CONE_K [3][3] = '{
        '{C00[29:0], C01[29:0], C02[29:0]},
        '{C10[29:0], C11[29:0], C12[29:0]},
        '{C20[29:0], C21[29:0], C22[29:0]}
    };

    // Lab matrix magnitudes, Q.28, round to nearest
    localparam logic [63:0] L00 = (64'd2104542553  * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L01 = (64'd7936177850  * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L02 = (64'd40720468    * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L10 = (64'd19779984951 * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L11 = (64'd24285922050 * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L12 = (64'd4505937099  * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L20 = (64'd259040371   * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L21 = (64'd7827717662  * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] L22 = (64'd8086757660  * 64'd268435456 + 64'd5000000000) / 64'd10000000000;

    localparam logic signed [31:0] LAB_K [3][3] = '{
        '{L00[31:0], L01[31:0], 32'(64'd0 - L02)},
        '{L10[31:0], 32'(64'd0 - L11), L12[31:0]},
        '{L20[31:0], L21[31:0], 32'(64'd0 - L22)}
    };

    localparam logic [16:0] MOD_BASE = 17'd65535;

    // Residue mod 2^16-1 by folding 16-bit digits
    function automatic logic [15:0] mod_65535(input logic [47:0] t);
        logic [17:0] s;
        logic [16:0] f;
        s = 18'(t[15:0]) + 18'(t[31:16]) + 18'(t[47:32]);
        f = 17'(s[15:0]) + 17'(s[17:16]);
        if (f >= MOD_BASE)
            return 16'(f - MOD_BASE);
        return f[15:0];
    endfunction

    // Exact quotient of a multiple of 2^16-1, valid while it fits 32 bits
    function automatic logic [31:0] exact_div_65535(input logic [47:0] m);
        return 32'd0 - (m[31:0] + {m[15:0], 16'd0});
    endfunction

endpackage

// ===== sv/linear_rgb_to_oklab_core.sv =====
// Linear sRGB to Oklab converter, top level.
// Path: cone matrix, cube root and Lab projection, from input transaction to result.
// Throughput: one transaction per cycle; the whole pipe advances together and
// holds while a finished result is stalled at the output register.
// Reset: rst_n clears every stage valid bit asynchronously; data regs keep junk.
// Depends on okl_pkg, okl_cone, okl_cbrt_step, okl_lab.
module linear_rgb_to_oklab_core
    import okl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] lightness,
    output logic signed [15:0] green_red_axis,
    output logic signed [15:0] blue_yellow_axis
);

    localparam int STEPS = ROOT_W;

    logic en;

    logic      vld_pipe [STEPS+1];
    okl_cube_t e_pipe   [STEPS+1];
    okl_root_t y_pipe   [STEPS+1];
    okl_sqr_t  y2_pipe  [STEPS+1];

    okl_q16_t  root;

    // Advance the pipe unless the result register holds an untaken transaction
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // RGB to LMS, scaled to Q0.51
    okl_cone u_cone (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .out_vld (vld_pipe[0]),
        .cone    (e_pipe[0])
    );

    assign y_pipe[0]  = '0;
    assign y2_pipe[0] = '0;

    // Cube root, one result bit per stage from the top bit down
    for (genvar k = 0; k < STEPS; k++)
    begin : g_root
        okl_cbrt_step #(.BIT(STEPS - 1 - k)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (vld_pipe[k]),
            .e_in    (e_pipe[k]),
            .y_in    (y_pipe[k]),
            .y2_in   (y2_pipe[k]),
            .out_vld (vld_pipe[k+1]),
            .e_out   (e_pipe[k+1]),
            .y_out   (y_pipe[k+1]),
            .y2_out  (y2_pipe[k+1])
        );
    end

    // Round Q0.17 root to Q0.16; a root of one lands on 65536
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            root[i] = 17'((ROOT_W + 1)'(y_pipe[STEPS][i]) + (ROOT_W + 1)'(1) >> 1);
    end

    // Lab projection, round to Q1.15, saturate
    okl_lab u_lab (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_vld           (vld_pipe[STEPS]),
        .root             (root),
        .out_vld          (out_valid),
        .lightness        (lightness),
        .green_red_axis   (green_red_axis),
        .blue_yellow_axis (blue_yellow_axis)
    );

    // Input is held off only by a stalled, full output register
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // Rounded roots never exceed one
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_pipe[STEPS] |-> (root[0] <= 17'd65536 && root[1] <= 17'd65536
        && root[2] <= 17'd65536))
        else $error("cube root out of range");

    // Frozen pipe keeps its root stage contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_pipe[STEPS]) && $stable(y_pipe[STEPS])))
        else $error("root stage changed while stalled");

    // Remainder stays below the next cube step at the last bit
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_pipe[STEPS] |-> (e_pipe[STEPS][0][CUBE_W-1:CUBE_W-2] == 2'b00))
        else $error("cube root remainder overflow");

endmodule

// ===== sv/okl_cone.sv =====
// Cone response stages: RGB to LMS matrix and scaling to Q0.51.
// Depends on okl_pkg.
module okl_cone
    import okl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output logic        out_vld,
    output okl_cube_t   cone
);

    logic [4:0] vld_reg;

    logic [45:0] prod_reg [3][3];
    logic [47:0] sum_reg  [3];
    logic [47:0] t3_reg   [3];
    logic [15:0] r3_reg   [3];
    logic [31:0] q4_reg   [3];
    logic [15:0] r4_reg   [3];
    logic [15:0] rr4_reg  [3];
    okl_cube_t   cone_reg;

    logic [15:0] pix [3];
    assign pix[0] = red;
    assign pix[1] = green;
    assign pix[2] = blue;

    // valid bits, advance with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= 46'(pix[j]) * 46'(CONE_K[i][j]);
                sum_reg[i] <= 48'(prod_reg[i][0]) + 48'(prod_reg[i][1]) + 48'(prod_reg[i][2]);
                t3_reg[i]  <= sum_reg[i];
                r3_reg[i]  <= mod_65535(sum_reg[i]);
                q4_reg[i]  <= exact_div_65535(t3_reg[i] - 48'(r3_reg[i]));
                r4_reg[i]  <= r3_reg[i];
                rr4_reg[i] <= mod_65535({11'd0, r3_reg[i], 21'd32767});
                cone_reg[i] <= CUBE_W'({q4_reg[i], 21'd0})
                    + CUBE_W'(exact_div_65535({11'd0, r4_reg[i], 21'd32767}
                    - 48'(rr4_reg[i])));
            end
        end
    end

    assign out_vld = vld_reg[4];
    assign cone    = cone_reg;

endmodule

// ===== sv/okl_cbrt_step.sv =====
// One bit of the digit-by-digit cube root, for all three cone channels.
// Depends on okl_pkg.
module okl_cbrt_step
    import okl_pkg::*;
#(
    parameter int BIT = 17
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_vld,
    input  okl_cube_t e_in,
    input  okl_root_t y_in,
    input  okl_sqr_t  y2_in,
    output logic      out_vld,
    output okl_cube_t e_out,
    output okl_root_t y_out,
    output okl_sqr_t  y2_out
);

    logic      vld_reg;
    okl_cube_t e_reg, e_next;
    okl_root_t y_reg, y_next;
    okl_sqr_t  y2_reg, y2_next;

    // trial: (y + 2^b)^3 - y^3 against the remainder
    always_comb
    begin
        logic [59:0] term;
        for (int i = 0; i < 3; i++)
        begin
            term = ((60'(y2_in[i]) * 60'd3) << BIT) + ((60'(y_in[i]) * 60'd3) << (2 * BIT))
                + (60'd1 << (3 * BIT));
            if (term <= 60'(e_in[i]))
            begin
                e_next[i]  = e_in[i] - term[CUBE_W-1:0];
                y_next[i]  = y_in[i] | (ROOT_W'(1) << BIT);
                y2_next[i] = y2_in[i] + (SQR_W'(y_in[i]) << (BIT + 1)) + (SQR_W'(1) << (2 * BIT));
            end
            else
            begin
                e_next[i]  = e_in[i];
                y_next[i]  = y_in[i];
                y2_next[i] = y2_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg  <= e_next;
            y_reg  <= y_next;
            y2_reg <= y2_next;
        end
    end

    assign out_vld = vld_reg;
    assign e_out   = e_reg;
    assign y_out   = y_reg;
    assign y2_out  = y2_reg;

endmodule

// ===== sv/okl_lab.sv =====
// Output stages: Lab matrix on the roots, rounding and saturation.
// Depends on okl_pkg.
module okl_lab
    import okl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  okl_q16_t    root,
    output logic        out_vld,
    output logic [14:0] lightness,
    output logic signed [15:0] green_red_axis,
    output logic signed [15:0] blue_yellow_axis
);

    logic [1:0] vld_reg;
    logic signed [49:0] prod_reg [3][3];
    logic [14:0] light_reg;
    logic signed [15:0] ga_reg;
    logic signed [15:0] by_reg;

    logic signed [51:0] acc [3];
    logic signed [22:0] sh  [3];
    logic [14:0] light_next;
    logic signed [15:0] ga_next;
    logic signed [15:0] by_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // add one half, then floor to Q1.15
            acc[i] = 52'(prod_reg[i][0]) + 52'(prod_reg[i][1]) + 52'(prod_reg[i][2])
                + (52'sd1 <<< 28);
            sh[i]  = 23'(acc[i] >>> 29);
        end
        if (sh[0] < 0)
            light_next = '0;
        else if (sh[0] > 23'sd32767)
            light_next = 15'h7FFF;
        else
            light_next = sh[0][14:0];
        if (sh[1] < -23'sd32768)
            ga_next = -16'sd32768;
        else if (sh[1] > 23'sd32767)
            ga_next = 16'sd32767;
        else
            ga_next = sh[1][15:0];
        if (sh[2] < -23'sd32768)
            by_next = -16'sd32768;
        else if (sh[2] > 23'sd32767)
            by_next = 16'sd32767;
        else
            by_next = sh[2][15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= 50'(LAB_K[i][j]) * 50'($signed({1'b0, root[j]}));
            light_reg <= light_next;
            ga_reg    <= ga_next;
            by_reg    <= by_next;
        end
    end

    assign out_vld          = vld_reg[1];
    assign lightness        = light_reg;
    assign green_red_axis   = ga_reg;
    assign blue_yellow_axis = by_reg;

endmodule

// ===== test/tb_linear_rgb_to_oklab_core.sv =====
// Testbench for linear_rgb_to_oklab_core: directed and random pixels checked
// against a bit-exact fixed-point predictor built in this file.
// Depends on the linear_rgb_to_oklab_core RTL.
`timescale 1ns / 1ps

module tb_linear_rgb_to_oklab_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red_axis;
        logic signed [15:0] blue_yellow_axis;
    } oklab_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] red = '0;
    logic [15:0] green = '0;
    logic [15:0] blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [14:0] lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;

    oklab_pixel_t expected_pixels[$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;

    // Fixed matrices, rebuilt here from the decimal coefficients (1e-10 units)
    longint cone_coef [3][3];
    longint lab_coef  [3][3];

    linear_rgb_to_oklab_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .lightness        (lightness),
        .green_red_axis   (green_red_axis),
        .blue_yellow_axis (blue_yellow_axis)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round a decimal coefficient to a fixed-point value with 'frac' bits
    function automatic longint to_fixed(input longint unsigned c10, input int frac);
        longint unsigned p;
        p = c10 * (64'd1 << frac) + 64'd5000000000;
        return longint'(p / 64'd10000000000);
    endfunction

    function automatic longint unsigned cone_response(input int row,
                                                      input logic [15:0] rgb [3]);
        longint unsigned acc;
        longint unsigned q;
        longint unsigned r;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += longint'(cone_coef[row][i]) * longint'({48'd0, rgb[i]});
        // No clamp to zero is needed: all terms are non-negative
        q = acc / 65535;
        r = acc % 65535;
        return (q << 21) + (((r << 21) + 32767) / 65535);
    endfunction

    function automatic longint cube_root(input longint unsigned v);
        longint unsigned y;
        longint unsigned c;
        y = 0;
        for (int b = 17; b >= 0; b--)
        begin
            c = y | (64'd1 << b);
            if (c * c * c <= v)
                y = c;
        end
        return longint'((y + 1) >> 1);
    endfunction

    function automatic oklab_pixel_t predict_oklab(input logic [15:0] r_in,
                                                  input logic [15:0] g_in,
                                                  input logic [15:0] b_in);
        logic [15:0]  rgb [3];
        longint       root [3];
        longint       proj [3];
        longint       acc;
        oklab_pixel_t px;
        rgb = '{r_in, g_in, b_in};
        for (int i = 0; i < 3; i++)
            root[i] = cube_root(cone_response(i, rgb));
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += lab_coef[i][j] * root[j];
            // Round half up to Q1.15: floor((acc + 2^28) / 2^29)
            proj[i] = (acc + (64'sd1 <<< 28)) >>> 29;
        end
        px.lightness = (proj[0] < 0) ? 15'd0 : (proj[0] > 32767) ? 15'd32767
                     : 15'(proj[0]);
        px.green_red_axis = (proj[1] < -32768) ? -16'sd32768
                          : (proj[1] > 32767) ? 16'sd32767 : 16'(proj[1]);
        px.blue_yellow_axis = (proj[2] < -32768) ? -16'sd32768
                            : (proj[2] > 32767) ? 16'sd32767 : 16'(proj[2]);
        return px;
    endfunction

    // Present one pixel, hold it until the transaction completes
    task automatic send_pixel(input logic [15:0] r_in, input logic [15:0] g_in,
                              input logic [15:0] b_in);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r_in;
        green    <= g_in;
        blue     <= b_in;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pixels.push_back(predict_oklab(r_in, g_in, b_in));
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    // Random channel value, biased toward the extremes now and then
    function automatic logic [15:0] rand_channel();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            3: return 16'hFFFF - 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_pixel(16'h0000, 16'h0000, 16'h0000);   // black
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);   // white, L saturates
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);   // pure primaries
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);   // secondaries
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'h0001, 16'h0001, 16'h0001);   // smallest non-zero
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0001, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0001);
        send_pixel(16'hFFFE, 16'hFFFE, 16'hFFFE);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);   // alternating bit patterns
        send_pixel(16'h5555, 16'hAAAA, 16'h5555);
        go_idle();
    endtask

    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
            send_pixel(rand_channel(), rand_channel(), rand_channel());
        go_idle();
    endtask

    // Randomize the output stall and check every completed transaction
    always @(posedge clk)
    begin
        oklab_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: lightness=%0d", lightness);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (lightness !== want.lightness)
                begin
                    $error("lightness: expected %0d, got %0d", want.lightness, lightness);
                    error_count++;
                end
                if (green_red_axis !== want.green_red_axis)
                begin
                    $error("green_red_axis: expected %0d, got %0d",
                           want.green_red_axis, green_red_axis);
                    error_count++;
                end
                if (blue_yellow_axis !== want.blue_yellow_axis)
                begin
                    $error("blue_yellow_axis: expected %0d, got %0d",
                           want.blue_yellow_axis, blue_yellow_axis);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cone_coef = '{
            '{to_fixed(64'd4122214708, 30), to_fixed(64'd5363325363, 30),
              to_fixed(64'd514459929, 30)},
            '{to_fixed(64'd2119034982, 30), to_fixed(64'd6806995451, 30),
              to_fixed(64'd1073969566, 30)},
            '{to_fixed(64'd883024619, 30),  to_fixed(64'd2817188376, 30),
              to_fixed(64'd6299787005, 30)}
        };
        lab_coef = '{
            '{to_fixed(64'd2104542553, 28),  to_fixed(64'd7936177850, 28),
              -to_fixed(64'd40720468, 28)},
            '{to_fixed(64'd19779984951, 28), -to_fixed(64'd24285922050, 28),
              to_fixed(64'd4505937099, 28)},
            '{to_fixed(64'd259040371, 28),   to_fixed(64'd7827717662, 28),
              -to_fixed(64'd8086757660, 28)}
        };

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        tx_idle_pct = 37;
        rx_idle_pct = 85;
        test_directed();
        test_random(170, 37, 85);
        test_random(170, 85, 37);
        test_random(170, 0, 0);

        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
